@@ design/secir_pkg.sv @@
// ----------------------------------------------------------------------------
// SECIR step package
// Shared item types, register indexes, step codes and the controller/datapath
// command and status records for the implicit Euler SECIR step.
// ----------------------------------------------------------------------------
package secir_pkg;

	localparam int CNT_W  = 48;
	localparam int CFG_W  = 64;
	localparam int CIDX_W = 3;
	localparam int ITER_W = 5;

	typedef struct packed {
		logic [CNT_W-1:0] susceptible_in;
		logic [CNT_W-1:0] exposed_in;
		logic [CNT_W-1:0] carrier_in;
		logic [CNT_W-1:0] infected_in;
		logic [CNT_W-1:0] hospital_in;
		logic [CNT_W-1:0] icu_in;
		logic [CNT_W-1:0] recovered_in;
		logic [CNT_W-1:0] dead_in;
		logic [31:0]      contact_rate;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0]  susceptible_out;
		logic [CNT_W-1:0]  exposed_out;
		logic [CNT_W-1:0]  carrier_out;
		logic [CNT_W-1:0]  infected_out;
		logic [CNT_W-1:0]  hospital_out;
		logic [CNT_W-1:0]  icu_out;
		logic [CNT_W-1:0]  recovered_out;
		logic [CNT_W-1:0]  dead_out;
		logic [ITER_W-1:0] iterations_used;
		logic              converged;
	} out_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_INFECTION_GAIN  = 3'd0,
		REG_RISK_TOLERANCE  = 3'd1,
		REG_EXPOSED_RATES   = 3'd2,
		REG_CARRIER_RATES   = 3'd3,
		REG_INFECTED_RATES  = 3'd4,
		REG_HOSPITAL_RATES  = 3'd5,
		REG_ICU_DEATH_RATE  = 3'd6
	} reg_idx_t;

	// One code per arithmetic step of the schedule.
	typedef enum logic [4:0] {
		ST_G, ST_W, ST_F, ST_S, ST_TE, ST_E, ST_TC, ST_C, ST_TI, ST_I,
		ST_TH, ST_H, ST_TU, ST_U, ST_R1, ST_R2, ST_R3, ST_R4, ST_D
	} step_t;

	typedef struct packed {
		step_t step;
		logic  load;
		logic  kick;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic conv_ok;
	} sts_t;

	localparam logic [6:0] SH_Q16  = 7'd16;
	localparam logic [6:0] SH_RISK = 7'd30;
	localparam logic [6:0] SH_Q56  = 7'd56;
	localparam logic [6:0] SH_Q24  = 7'd24;

	function automatic logic is_div(step_t s);
		return (s == ST_S) || (s == ST_E) || (s == ST_C) || (s == ST_I) ||
			(s == ST_H) || (s == ST_U);
	endfunction

endpackage

@@ design/secir_implicit_euler_step_top.sv @@
// ----------------------------------------------------------------------------
// SECIR implicit Euler step, top level
// One implicit Euler step of the eight-compartment SECIR model in fixed point.
// ----------------------------------------------------------------------------
// Each item runs the multiply and divide steps of the schedule in turn, one
// fixed-point pass at a time with a convergence check after each, for up to
// MAX_ITERATIONS passes. Throughput: one item at a time, the next item taken
// only once the block is back in idle; the shared 104-step divider sets the pace.
// Reset clears the configuration registers to zero and returns to idle. The
// result is shown for exactly one cycle with done; the receiver cannot stall.
module secir_implicit_euler_step_top #(
	parameter int MAX_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  secir_pkg::in_t                operands,
	output logic                          done,
	output secir_pkg::out_t               result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [secir_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [secir_pkg::CFG_W-1:0]   cfg_data
);
	import secir_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [8*CNT_W-1:0] counts;
	logic [ITER_W-1:0]  iters;
	logic               conv;

	// Registers are always writable; the user must issue writes only while idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	// The controller sequences the schedule; the datapath does the arithmetic.
	secir_ctrl #(
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.iters  (iters),
		.conv   (conv)
	);

	secir_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (operands),
		.cmd       (cmd),
		.sts       (sts),
		.counts    (counts)
	);

	// The compartment registers hold still while done is high.
	assign result = {counts, iters, conv};
endmodule

@@ design/secir_mul.sv @@
// ----------------------------------------------------------------------------
// SECIR multiplier
// 64 x 64 to 128 bit product built from four 32 x 32 partial products.
// ----------------------------------------------------------------------------
module secir_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	output logic          done,
	output logic [127:0]  prod
);
	logic [63:0]  a_q, b_q;
	logic         run_q;
	logic [1:0]   k_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic         v_s1, last_s1, done_q;
	logic [127:0] acc_q;
	logic [31:0]  ah, bh;

	assign ah = k_q[1] ? a_q[63:32] : a_q[31:0];
	assign bh = k_q[0] ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= run_q;
			last_s1 <= run_q && (k_q == 2'd3);
			done_q  <= v_s1 && last_s1;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= ah * bh;
		sh_s1 <= {1'b0, k_q[1]} + {1'b0, k_q[0]};
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + ({64'd0, pp_s1} << {sh_s1, 5'd0});
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ design/secir_div.sv @@
// ----------------------------------------------------------------------------
// SECIR divider
// Restoring divider, one quotient bit per cycle, quotient saturated to a count.
// ----------------------------------------------------------------------------
module secir_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [103:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [47:0]  quo
);
	localparam int NW = 104;
	localparam int CW = $clog2(NW);

	logic [NW-1:0] nq_q;
	logic [63:0]   rem_q, d_q, rnext;
	logic [64:0]   r65;
	logic          ge, run_q, done_q;
	logic [CW-1:0] cnt_q;

	assign r65   = {rem_q, nq_q[NW-1]};
	assign ge    = r65 >= {1'b0, d_q};
	assign rnext = ge ? 64'(r65 - {1'b0, d_q}) : r65[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(NW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			d_q   <= den;
		end else if (run_q) begin
			nq_q  <= {nq_q[NW-2:0], ge};
			rem_q <= rnext;
		end
	end

	assign done = done_q;
	assign quo  = (|nq_q[NW-1:48]) ? '1 : nq_q[47:0];
endmodule

@@ design/secir_dp.sv @@
// ----------------------------------------------------------------------------
// SECIR datapath
// Configuration registers, compartment registers, shared multiplier and
// divider, and the operand selection for each step of the schedule.
// ----------------------------------------------------------------------------
module secir_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [secir_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [secir_pkg::CFG_W-1:0]    cfg_data,
	input  secir_pkg::in_t                 item,
	input  secir_pkg::cmd_t                cmd,
	output secir_pkg::sts_t                sts,
	output logic [8*secir_pkg::CNT_W-1:0]  counts
);
	import secir_pkg::*;

	localparam logic [63:0] CAP_CNT = 64'(48'hFFFF_FFFF_FFFF);
	localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;
	localparam logic [63:0] ONE_Q24 = 64'h0000_0000_0100_0000;

	logic [63:0] gain_q, risk_tol_q, exp_q, car_q, inf_q, hos_q;
	logic [31:0] ud_q;
	in_t         in_q;
	logic [63:0] g_q, f_q, mp_q;
	logic [CNT_W-1:0] w_q, s_q, e_q, c_q, i_q, pc_q, pi_q, t_q, h_q, u_q, r_q, d_q;
	logic        post_q;

	logic [63:0]  ma, mb, addend, dden;
	logic [6:0]   shamt;
	logic         cap64;
	logic [103:0] dnum;
	logic         mul_done, div_done;
	logic [127:0] prod, shifted;
	logic [63:0]  capped, post_val;
	logic [64:0]  sum65, den65;
	logic [47:0]  quo;
	logic [47:0]  dc, di;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= '0;
			risk_tol_q <= '0;
			exp_q      <= '0;
			car_q      <= '0;
			inf_q      <= '0;
			hos_q      <= '0;
			ud_q       <= '0;
			post_q     <= 1'b0;
		end else begin
			post_q <= mul_done;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INFECTION_GAIN: gain_q     <= cfg_data;
					REG_RISK_TOLERANCE: risk_tol_q <= cfg_data;
					REG_EXPOSED_RATES:  exp_q      <= cfg_data;
					REG_CARRIER_RATES:  car_q      <= cfg_data;
					REG_INFECTED_RATES: inf_q      <= cfg_data;
					REG_HOSPITAL_RATES: hos_q      <= cfg_data;
					REG_ICU_DEATH_RATE: ud_q       <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	// Multiply step operands: product, shift, cap, then a saturating add.
	always_comb begin
		ma     = '0;
		mb     = '0;
		shamt  = SH_Q24;
		cap64  = 1'b0;
		addend = '0;
		unique case (cmd.step)
			ST_G: begin
				ma = gain_q; mb = 64'(in_q.contact_rate); shamt = SH_Q16; cap64 = 1'b1;
			end
			ST_W: begin
				ma = 64'(risk_tol_q[63:32]); mb = 64'(i_q); shamt = SH_RISK;
				addend = 64'(c_q);
			end
			ST_F: begin
				ma = g_q; mb = 64'(w_q); shamt = SH_Q16; cap64 = 1'b1;
			end
			ST_TE: begin
				ma = f_q; mb = 64'(s_q); shamt = SH_Q56; addend = 64'(in_q.exposed_in);
			end
			ST_TC: begin
				ma = 64'(exp_q[63:32]); mb = 64'(e_q); addend = 64'(in_q.carrier_in);
			end
			ST_TI: begin
				ma = 64'(exp_q[31:0]); mb = 64'(c_q); addend = 64'(in_q.infected_in);
			end
			ST_TH: begin
				ma = 64'(inf_q[63:32]); mb = 64'(i_q); addend = 64'(in_q.hospital_in);
			end
			ST_TU: begin
				ma = 64'(hos_q[63:32]); mb = 64'(h_q); addend = 64'(in_q.icu_in);
			end
			ST_R1: begin
				ma = 64'(car_q[63:32]); mb = 64'(c_q); addend = 64'(in_q.recovered_in);
			end
			ST_R2: begin
				ma = 64'(car_q[31:0]); mb = 64'(i_q); addend = 64'(r_q);
			end
			ST_R3: begin
				ma = 64'(inf_q[31:0]); mb = 64'(h_q); addend = 64'(r_q);
			end
			ST_R4: begin
				ma = 64'(hos_q[31:0]); mb = 64'(u_q); addend = 64'(r_q);
			end
			ST_D: begin
				ma = 64'(ud_q); mb = 64'(u_q); addend = 64'(in_q.dead_in);
			end
			default: ;
		endcase
	end

	// Division step operands; every divisor is one plus nonnegative rates.
	assign den65 = {1'b0, ONE_Q56} + {1'b0, f_q};
	always_comb begin
		dnum = {32'd0, t_q, 24'd0};
		dden = ONE_Q24;
		unique case (cmd.step)
			ST_S: begin
				dnum = {in_q.susceptible_in, 56'd0};
				dden = den65[64] ? '1 : den65[63:0];
			end
			ST_E: dden = ONE_Q24 + 64'(exp_q[63:32]);
			ST_C: dden = ONE_Q24 + 64'(exp_q[31:0]) + 64'(car_q[63:32]);
			ST_I: dden = ONE_Q24 + 64'(car_q[31:0]) + 64'(inf_q[63:32]);
			ST_H: dden = ONE_Q24 + 64'(inf_q[31:0]) + 64'(hos_q[63:32]);
			ST_U: dden = ONE_Q24 + 64'(hos_q[31:0]) + 64'(ud_q);
			default: ;
		endcase
	end

	secir_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.kick && !is_div(cmd.step)),
		.a      (ma),
		.b      (mb),
		.done   (mul_done),
		.prod   (prod)
	);

	secir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.kick && is_div(cmd.step)),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (quo)
	);

	assign shifted = prod >> shamt;
	always_comb begin
		if (cap64) begin
			capped = (|shifted[127:64]) ? '1 : shifted[63:0];
		end else begin
			capped = (|shifted[127:48]) ? CAP_CNT : shifted[63:0];
		end
	end

	assign sum65 = {1'b0, addend} + {1'b0, mp_q};
	always_comb begin
		if (cap64) begin
			post_val = sum65[64] ? '1 : sum65[63:0];
		end else begin
			post_val = (|sum65[64:48]) ? CAP_CNT : sum65[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mul_done) begin
			mp_q <= capped;
		end
		if (cmd.load) begin
			in_q <= item;
			c_q  <= item.carrier_in;
			i_q  <= item.infected_in;
		end
		if (cmd.kick && cmd.step == ST_W) begin
			pc_q <= c_q;
			pi_q <= i_q;
		end
		if (post_q) begin
			unique case (cmd.step)
				ST_G: g_q <= post_val;
				ST_W: w_q <= post_val[CNT_W-1:0];
				ST_F: f_q <= post_val;
				ST_R1, ST_R2, ST_R3, ST_R4: r_q <= post_val[CNT_W-1:0];
				ST_D: d_q <= post_val[CNT_W-1:0];
				default: t_q <= post_val[CNT_W-1:0];
			endcase
		end
		if (div_done) begin
			unique case (cmd.step)
				ST_S: s_q <= quo;
				ST_E: e_q <= quo;
				ST_C: c_q <= quo;
				ST_I: i_q <= quo;
				ST_H: h_q <= quo;
				default: u_q <= quo;
			endcase
		end
	end

	assign dc = (c_q > pc_q) ? c_q - pc_q : pc_q - c_q;
	assign di = (i_q > pi_q) ? i_q - pi_q : pi_q - i_q;

	assign sts.done    = post_q || div_done;
	assign sts.conv_ok = (dc <= 48'(risk_tol_q[31:0])) && (di <= 48'(risk_tol_q[31:0]));
	assign counts      = {s_q, e_q, c_q, i_q, h_q, u_q, r_q, d_q};
endmodule

@@ design/secir_ctrl.sv @@
// ----------------------------------------------------------------------------
// SECIR controller
// Walks the step schedule, counts fixed-point passes and decides when the
// carrier/infected loop ends.
// ----------------------------------------------------------------------------
module secir_ctrl #(
	parameter int MAX_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  secir_pkg::sts_t               sts,
	output secir_pkg::cmd_t               cmd,
	output logic                          busy,
	output logic                          done,
	output logic [secir_pkg::ITER_W-1:0]  iters,
	output logic                          conv
);
	import secir_pkg::*;

	localparam int IW = $clog2(MAX_ITERATIONS + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_KICK  = 5'b00010,
		S_WAIT  = 5'b00100,
		S_CHECK = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t  state_q;
	step_t   step_q;
	logic [IW-1:0] iter_q;
	logic    conv_q;
	logic    accept;

	function automatic step_t next_step(step_t s);
		step_t n;
		unique case (s)
			ST_G:    n = ST_W;
			ST_W:    n = ST_F;
			ST_F:    n = ST_S;
			ST_S:    n = ST_TE;
			ST_TE:   n = ST_E;
			ST_E:    n = ST_TC;
			ST_TC:   n = ST_C;
			ST_C:    n = ST_TI;
			ST_TI:   n = ST_I;
			ST_TH:   n = ST_H;
			ST_H:    n = ST_TU;
			ST_TU:   n = ST_U;
			ST_U:    n = ST_R1;
			ST_R1:   n = ST_R2;
			ST_R2:   n = ST_R3;
			ST_R3:   n = ST_R4;
			ST_R4:   n = ST_D;
			default: n = ST_D;
		endcase
		return n;
	endfunction

	assign accept = start && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_G;
			iter_q  <= '0;
			conv_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= ST_G;
						iter_q  <= '0;
						conv_q  <= 1'b0;
						state_q <= S_KICK;
					end
				end
				S_KICK: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.done) begin
						priority if (step_q == ST_I) begin
							state_q <= S_CHECK;
						end else if (step_q == ST_D) begin
							state_q <= S_DONE;
						end else begin
							step_q  <= next_step(step_q);
							state_q <= S_KICK;
						end
					end
				end
				S_CHECK: begin
					iter_q  <= iter_q + 1'b1;
					state_q <= S_KICK;
					priority if (sts.conv_ok) begin
						conv_q <= 1'b1;
						step_q <= ST_TH;
					end else if (IW'(iter_q + 1'b1) == IW'(MAX_ITERATIONS)) begin
						step_q <= ST_TH;
					end else begin
						step_q <= ST_W;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.step = step_q;
	assign cmd.load = accept;
	assign cmd.kick = (state_q == S_KICK);
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE);
	assign iters    = ITER_W'(iter_q);
	assign conv     = conv_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");
	a_kick_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.kick |=> !cmd.kick) else $error("unit started twice in a row");
	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (iter_q <= IW'(MAX_ITERATIONS))) else $error("pass count beyond cap");
	a_done_iters: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (iter_q != '0)) else $error("result without any pass");
endmodule

@@ sim/secir_implicit_euler_step_top_tb.sv @@
// ----------------------------------------------------------------------------
// SECIR implicit Euler step testbench
// Drives step items and register writes into the block and predicts each new
// set of compartment sizes in fixed point. Every result is checked field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module secir_implicit_euler_step_top_tb;
	import secir_pkg::*;

	localparam int STEP_PASSES = 16;
	localparam logic [CIDX_W-1:0] REG_NONE = 3'd7;

	// Keeps the register copy and the queue of predicted step results.
	class secir_step_tracker;
		localparam logic [63:0] CNT_CAP = 64'hFFFF_FFFF_FFFF;
		localparam logic [63:0] WORD_CAP = 64'hFFFF_FFFF_FFFF_FFFF;
		localparam logic [63:0] ONE_Q24 = 64'h100_0000;
		localparam logic [63:0] ONE_Q56 = 64'h100_0000_0000_0000;

		logic [63:0] regs [7];
		out_t expected_steps [$];
		int errors;

		function new();
			foreach (regs[k])
				regs[k] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
			if (idx == REG_ICU_DEATH_RATE)
				regs[idx] = {32'd0, data[31:0]};
			else if (idx < 7)
				regs[idx] = data;
		endfunction

		function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh,
			logic [63:0] cap);
			logic [127:0] p;
			p = ({64'd0, a} * {64'd0, b}) >> sh;
			return (p > {64'd0, cap}) ? cap : p[63:0];
		endfunction

		function logic [63:0] mul_quot(logic [63:0] a, logic [63:0] b, logic [63:0] d,
			logic [63:0] cap);
			logic [127:0] q;
			q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
			return (q > {64'd0, cap}) ? cap : q[63:0];
		endfunction

		function logic [63:0] add_cap(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return (s > {1'b0, cap}) ? cap : s[63:0];
		endfunction

		function logic [63:0] gap_of(logic [63:0] a, logic [63:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		// Runs the S-E-C-I loop until C and I settle or the pass cap is reached, then the H-U-R-D tail.
		function out_t predict(in_t op);
			out_t o;
			logic [63:0] risk, tol, e_c, c_i, c_r, i_r, i_h, h_r, h_u, u_r, u_d;
			logic [63:0] g, w, f, den, t, s, e, c, i, h, u, rr, d, pc, pi;
			int passes;
			bit settled;
			risk = regs[REG_RISK_TOLERANCE] >> 32;
			tol = regs[REG_RISK_TOLERANCE] & 64'hFFFF_FFFF;
			e_c = regs[REG_EXPOSED_RATES] >> 32;
			c_i = regs[REG_EXPOSED_RATES] & 64'hFFFF_FFFF;
			c_r = regs[REG_CARRIER_RATES] >> 32;
			i_r = regs[REG_CARRIER_RATES] & 64'hFFFF_FFFF;
			i_h = regs[REG_INFECTED_RATES] >> 32;
			h_r = regs[REG_INFECTED_RATES] & 64'hFFFF_FFFF;
			h_u = regs[REG_HOSPITAL_RATES] >> 32;
			u_r = regs[REG_HOSPITAL_RATES] & 64'hFFFF_FFFF;
			u_d = regs[REG_ICU_DEATH_RATE];
			g = mul_shift(regs[REG_INFECTION_GAIN], {32'd0, op.contact_rate}, 16, WORD_CAP);
			c = 64'(op.carrier_in);
			i = 64'(op.infected_in);
			s = '0;
			e = '0;
			passes = 0;
			settled = 0;
			for (int n = 1; n <= STEP_PASSES; n++) begin
				pc = c;
				pi = i;
				w = add_cap(c, mul_shift(risk, i, 30, CNT_CAP), CNT_CAP);
				f = mul_shift(g, w, 16, WORD_CAP);
				den = add_cap(ONE_Q56, f, WORD_CAP);
				s = mul_quot(64'(op.susceptible_in), ONE_Q56, den, CNT_CAP);
				t = add_cap(64'(op.exposed_in), mul_shift(f, s, 56, CNT_CAP), CNT_CAP);
				e = mul_quot(t, ONE_Q24, ONE_Q24 + e_c, CNT_CAP);
				t = add_cap(64'(op.carrier_in), mul_shift(e_c, e, 24, CNT_CAP), CNT_CAP);
				c = mul_quot(t, ONE_Q24, ONE_Q24 + c_i + c_r, CNT_CAP);
				t = add_cap(64'(op.infected_in), mul_shift(c_i, c, 24, CNT_CAP), CNT_CAP);
				i = mul_quot(t, ONE_Q24, ONE_Q24 + i_r + i_h, CNT_CAP);
				passes = n;
				if (gap_of(c, pc) <= tol && gap_of(i, pi) <= tol) begin
					settled = 1;
					break;
				end
			end
			t = add_cap(64'(op.hospital_in), mul_shift(i_h, i, 24, CNT_CAP), CNT_CAP);
			h = mul_quot(t, ONE_Q24, ONE_Q24 + h_r + h_u, CNT_CAP);
			t = add_cap(64'(op.icu_in), mul_shift(h_u, h, 24, CNT_CAP), CNT_CAP);
			u = mul_quot(t, ONE_Q24, ONE_Q24 + u_r + u_d, CNT_CAP);
			rr = add_cap(64'(op.recovered_in), mul_shift(c_r, c, 24, CNT_CAP), CNT_CAP);
			rr = add_cap(rr, mul_shift(i_r, i, 24, CNT_CAP), CNT_CAP);
			rr = add_cap(rr, mul_shift(h_r, h, 24, CNT_CAP), CNT_CAP);
			rr = add_cap(rr, mul_shift(u_r, u, 24, CNT_CAP), CNT_CAP);
			d = add_cap(64'(op.dead_in), mul_shift(u_d, u, 24, CNT_CAP), CNT_CAP);
			o.susceptible_out = s[CNT_W-1:0];
			o.exposed_out = e[CNT_W-1:0];
			o.carrier_out = c[CNT_W-1:0];
			o.infected_out = i[CNT_W-1:0];
			o.hospital_out = h[CNT_W-1:0];
			o.icu_out = u[CNT_W-1:0];
			o.recovered_out = rr[CNT_W-1:0];
			o.dead_out = d[CNT_W-1:0];
			o.iterations_used = passes[ITER_W-1:0];
			o.converged = settled;
			return o;
		endfunction

		function void note_step(in_t op);
			expected_steps.push_back(predict(op));
		endfunction

		function void field(string name, logic [63:0] exp, logic [63:0] act);
			if (act !== exp) begin
				$error("%s: expected %0h, got %0h", name, exp, act);
				errors++;
			end
		endfunction

		function void check_step(out_t got);
			out_t exp;
			if (expected_steps.size() == 0) begin
				$error("step result arrived with no item outstanding");
				errors++;
				return;
			end
			exp = expected_steps.pop_front();
			field("susceptible_out", 64'(exp.susceptible_out), 64'(got.susceptible_out));
			field("exposed_out", 64'(exp.exposed_out), 64'(got.exposed_out));
			field("carrier_out", 64'(exp.carrier_out), 64'(got.carrier_out));
			field("infected_out", 64'(exp.infected_out), 64'(got.infected_out));
			field("hospital_out", 64'(exp.hospital_out), 64'(got.hospital_out));
			field("icu_out", 64'(exp.icu_out), 64'(got.icu_out));
			field("recovered_out", 64'(exp.recovered_out), 64'(got.recovered_out));
			field("dead_out", 64'(exp.dead_out), 64'(got.dead_out));
			field("iterations_used", 64'(exp.iterations_used), 64'(got.iterations_used));
			field("converged", 64'(exp.converged), 64'(got.converged));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t operands;
	logic done;
	out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	secir_step_tracker tracker = new();

	secir_implicit_euler_step_top #(
		.MAX_ITERATIONS(STEP_PASSES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operands(operands),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver cannot stall, so every cycle with done high carries a result.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_step(result);
	end

	// Writes one register and mirrors it into the predictor on the handshake.
	// Valid stays high so that writes can follow back to back.
	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic write_all(logic [63:0] v [7]);
		for (int k = 0; k < 7; k++)
			write_reg(k[CIDX_W-1:0], v[k]);
		// The spare index must leave every register untouched.
		write_reg(REG_NONE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// Offers one item; start stays high until the block takes it. Idle
	// cycles are only inserted before the offer, so start is assigned once
	// per edge and stays high when items follow back to back.
	task automatic send_step(in_t op, int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		operands <= op;
		do
			@(posedge clk);
		while (busy);
		tracker.note_step(op);
	endtask

	// Waits for every outstanding result, then lets the block settle.
	task automatic drain();
		start <= 1'b0;
		while (tracker.expected_steps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [CNT_W-1:0] rand_count();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return r[CNT_W-1:0];
			1: return '1;
			2: return '0;
			default: return r[CNT_W-1:0] >> $urandom_range(0, CNT_W - 1);
		endcase
	endfunction

	function automatic in_t rand_step();
		in_t op;
		op.susceptible_in = rand_count();
		op.exposed_in = rand_count();
		op.carrier_in = rand_count();
		op.infected_in = rand_count();
		op.hospital_in = rand_count();
		op.icu_in = rand_count();
		op.recovered_in = rand_count();
		op.dead_in = rand_count();
		op.contact_rate = ($urandom_range(0, 3) == 0) ? $urandom : $urandom >> $urandom_range(0, 31);
		return op;
	endfunction

	function automatic logic [31:0] rand_rate();
		return $urandom >> $urandom_range(7, 31);
	endfunction

	// Plausible epidemic rates; zero_tol forces the loop up to its cap.
	task automatic write_random_regs(bit zero_tol);
		logic [63:0] v [7];
		logic [31:0] tol;
		tol = zero_tol ? 32'd0 : $urandom >> $urandom_range(0, 16);
		v[REG_INFECTION_GAIN] = {$urandom, $urandom} >> $urandom_range(4, 63);
		v[REG_RISK_TOLERANCE] = {$urandom >> $urandom_range(0, 31), tol};
		v[REG_EXPOSED_RATES] = {rand_rate(), rand_rate()};
		v[REG_CARRIER_RATES] = {rand_rate(), rand_rate()};
		v[REG_INFECTED_RATES] = {rand_rate(), rand_rate()};
		v[REG_HOSPITAL_RATES] = {rand_rate(), rand_rate()};
		v[REG_ICU_DEATH_RATE] = {$urandom, rand_rate()};
		write_all(v);
	endtask

	initial begin
		logic [63:0] v [7];
		in_t op;
		arst_n <= 1'b0;
		start <= 1'b0;
		operands <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset value: every rate is zero, so the sizes
		// pass through unchanged and the loop settles on its first pass.
		send_step('0, 0);
		send_step('1, 0);
		for (int k = 0; k < 3; k++)
			send_step(rand_step(), 0);
		drain();

		// Every register at all ones drives the counts into saturation.
		foreach (v[k])
			v[k] = '1;
		write_all(v);
		send_step('1, 0);
		send_step('0, 0);
		for (int k = 0; k < 4; k++)
			send_step(rand_step(), 0);
		drain();

		// Zero tolerance keeps the loop running until the pass cap.
		write_random_regs(1);
		for (int k = 0; k < 6; k++)
			send_step(rand_step(), 0);
		drain();

		// Registers back to zero, checking the clear path as well.
		foreach (v[k])
			v[k] = '0;
		write_all(v);
		send_step(rand_step(), 0);
		drain();

		// Random phases, each with fresh registers and one of three idling levels.
		for (int p = 0; p < 12; p++) begin
			int idle_pct;
			int count;
			case (p % 4)
				0: idle_pct = 0;
				1: idle_pct = 65;
				2: idle_pct = 0;
				default: idle_pct = 26;
			endcase
			write_random_regs(p == 5);
			count = (p == 5) ? 20 : 138;
			for (int k = 0; k < count; k++) begin
				op = rand_step();
				send_step(op, idle_pct);
			end
			drain();
		end

		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Allows every item the full pass cap plus generous idle gaps.
	initial begin
		#600000000;
		$display("simulation failed");
		$finish;
	end

endmodule
